### design/tnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnd_pkg
// shared constants and types for the decimal line to tone divider
// ----------------------------------------------------------------------------
package tnd_pkg;

    localparam int LINE_BUFFER_LEN = 128;
    localparam int CNT_W           = $clog2(LINE_BUFFER_LEN);
    localparam int VALUE_W         = 32;
    localparam int DIV_OUT_W       = 16;
    localparam int BIT_CNT_W       = $clog2(VALUE_W);

    localparam logic [VALUE_W-1:0] CLOCK_HZ_RESET = 32'd1193182;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAC  = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [VALUE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [VALUE_W-1:0] quotient;
    } div_rsp_t;

endpackage

### design/tnd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnd channel interfaces
// valid/ready channels for bytes, tone results and the clock register
// ----------------------------------------------------------------------------
interface tnd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface tnd_tone_if;
    logic                                     valid;
    logic                                     ready;
    logic [tnd_pkg::VALUE_W-1:0]              tone_freq;
    logic [tnd_pkg::DIV_OUT_W-1:0]            divider;
    logic                                     speaker_on;

    modport source (output valid, output tone_freq, output divider, output speaker_on,
                    input ready);
    modport sink   (input valid, input tone_freq, input divider, input speaker_on,
                    output ready);
endinterface

interface tnd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tnd_pkg::VALUE_W-1:0] input_clock_hz;

    modport source (output valid, output input_clock_hz, input ready);
    modport sink   (input valid, input input_clock_hz, output ready);
endinterface

### design/tnd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnd_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tnd_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  tnd_pkg::div_req_t req,
    output tnd_pkg::div_rsp_t rsp
);

    logic                                busy_reg, busy_next;
    logic [tnd_pkg::BIT_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [tnd_pkg::VALUE_W-1:0]         rem_reg, rem_next;
    logic [tnd_pkg::VALUE_W-1:0]         quo_reg, quo_next;
    logic [tnd_pkg::VALUE_W-1:0]         dsr_reg, dsr_next;
    logic [tnd_pkg::VALUE_W:0]           trial;
    logic [tnd_pkg::VALUE_W:0]           diff;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[tnd_pkg::VALUE_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[tnd_pkg::VALUE_W])
            begin
                rem_next = diff[tnd_pkg::VALUE_W-1:0];
                quo_next = {quo_reg[tnd_pkg::VALUE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[tnd_pkg::VALUE_W-1:0];
                quo_next = {quo_reg[tnd_pkg::VALUE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tnd_pkg::BIT_CNT_W'(tnd_pkg::VALUE_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule

### design/decimal_line_to_tone_divider_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_line_to_tone_divider_core
// parses decimal text lines and returns frequency, enable and timer divider
// ----------------------------------------------------------------------------
//  channel    dir   word
//  char_in    in    char_byte
//  tone_out   out   tone_freq, divider, speaker_on
//  cfg        in    input_clock_hz
//
//  a digit that extends a number runs the bit-serial times-ten-plus-digit
//  update of the 32-bit value; other bytes are taken directly in the idle state
//  a newline waits in the divide state for the one-bit-per-cycle restoring divider
//  reset clears the parser and loads the clock register with 1193182
//  the result waits in an output register; a stalled output holds the next
//  newline in the divide state until the register frees up
// ----------------------------------------------------------------------------
module decimal_line_to_tone_divider_core
(
    input  logic       clk,
    input  logic       rst_n,
    tnd_byte_if.sink   char_in,
    tnd_tone_if.source tone_out,
    tnd_cfg_if.sink    cfg
);

    tnd_pkg::state_t                   state_reg, state_next;
    tnd_pkg::phase_t                   phase_reg, phase_next;
    logic                              neg_reg, neg_next;
    logic [tnd_pkg::VALUE_W-1:0]       value_reg, value_next;
    logic [tnd_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [tnd_pkg::VALUE_W-1:0]       clk_hz_reg;
    logic [3:0]                        dig_reg, dig_next;
    logic [2:0]                        hist_reg, hist_next;
    logic [1:0]                        carry_reg, carry_next;
    logic [tnd_pkg::BIT_CNT_W-1:0]     bit_reg, bit_next;
    logic [tnd_pkg::VALUE_W-1:0]       freq_reg, freq_next;
    logic                              ovld_reg, ovld_next;
    logic [tnd_pkg::VALUE_W-1:0]       ofreq_reg, ofreq_next;
    logic [tnd_pkg::DIV_OUT_W-1:0]     odiv_reg, odiv_next;
    logic [2:0]                        sum;
    logic [7:0]                        c;
    logic                              accept;
    logic                              is_digit;
    logic                              is_blank;
    logic [tnd_pkg::CNT_W:0]           count_inc;
    tnd_pkg::div_req_t                 div_req;
    tnd_pkg::div_rsp_t                 div_rsp;

    tnd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign c         = char_in.char_byte;
    assign accept    = char_in.valid && char_in.ready;
    assign is_digit  = (c >= tnd_pkg::CH_ZERO) && (c <= tnd_pkg::CH_NINE);
    assign is_blank  = (c == tnd_pkg::CH_SPACE)
                       || ((c >= tnd_pkg::CH_TAB) && (c <= tnd_pkg::CH_CR));
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign sum       = {2'b00, hist_reg[0]} + {2'b00, hist_reg[2]} + {2'b00, dig_reg[0]}
                       + {1'b0, carry_reg};

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        value_next = value_reg;
        count_next = count_reg;
        dig_next   = dig_reg;
        hist_next  = hist_reg;
        carry_next = carry_reg;
        bit_next   = bit_reg;
        freq_next  = freq_reg;
        ovld_next  = ovld_reg;
        ofreq_next = ofreq_reg;
        odiv_next  = odiv_reg;
        div_req    = '{start: 1'b0, dividend: clk_hz_reg, divisor: freq_reg};

        if (ovld_reg && tone_out.ready)
        begin
            ovld_next = 1'b0;
        end

        unique case (state_reg)
            tnd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (c == tnd_pkg::CH_NEWLINE)
                    begin
                        freq_next        = neg_reg ? (tnd_pkg::VALUE_W'(0) - value_reg) : value_reg;
                        div_req.start    = 1'b1;
                        div_req.divisor  = freq_next;
                        state_next       = tnd_pkg::ST_DIV;
                        phase_next       = tnd_pkg::PH_SKIP;
                        neg_next         = 1'b0;
                        value_next       = '0;
                        count_next       = '0;
                    end
                    else if (count_inc >= (tnd_pkg::CNT_W + 1)'(tnd_pkg::LINE_BUFFER_LEN - 1))
                    begin
                        phase_next = tnd_pkg::PH_SKIP;
                        neg_next   = 1'b0;
                        value_next = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc[tnd_pkg::CNT_W-1:0];
                        unique case (phase_reg)
                            tnd_pkg::PH_SKIP:
                            begin
                                if (is_blank)
                                begin
                                    phase_next = tnd_pkg::PH_SKIP;
                                end
                                else if ((c == tnd_pkg::CH_PLUS) || (c == tnd_pkg::CH_MINUS))
                                begin
                                    neg_next   = (c == tnd_pkg::CH_MINUS);
                                    phase_next = tnd_pkg::PH_DIGITS;
                                end
                                else if (is_digit)
                                begin
                                    value_next = {{(tnd_pkg::VALUE_W-4){1'b0}}, c[3:0]};
                                    phase_next = tnd_pkg::PH_DIGITS;
                                end
                                else
                                begin
                                    phase_next = tnd_pkg::PH_DONE;
                                end
                            end
                            tnd_pkg::PH_DIGITS:
                            begin
                                if (is_digit)
                                begin
                                    dig_next   = c[3:0];
                                    hist_next  = '0;
                                    carry_next = '0;
                                    bit_next   = '0;
                                    state_next = tnd_pkg::ST_MAC;
                                end
                                else
                                begin
                                    phase_next = tnd_pkg::PH_DONE;
                                end
                            end
                            tnd_pkg::PH_DONE:
                            begin
                                phase_next = tnd_pkg::PH_DONE;
                            end
                            default:
                            begin
                                phase_next = tnd_pkg::PH_SKIP;
                            end
                        endcase
                    end
                end
            end
            tnd_pkg::ST_MAC:
            begin
                // value*10 + digit, lsb first: bit i sums v[i-1], v[i-3], digit bit i and the carry
                value_next = {sum[0], value_reg[tnd_pkg::VALUE_W-1:1]};
                hist_next  = {hist_reg[1], hist_reg[0], value_reg[0]};
                carry_next = sum[2:1];
                dig_next   = {1'b0, dig_reg[3:1]};
                bit_next   = bit_reg + 1'b1;
                if (bit_reg == tnd_pkg::BIT_CNT_W'(tnd_pkg::VALUE_W - 1))
                begin
                    state_next = tnd_pkg::ST_IDLE;
                end
            end
            tnd_pkg::ST_DIV:
            begin
                if (!div_rsp.busy && (!ovld_reg || tone_out.ready))
                begin
                    ovld_next  = 1'b1;
                    ofreq_next = freq_reg;
                    odiv_next  = (freq_reg == '0) ? '0
                                 : div_rsp.quotient[tnd_pkg::DIV_OUT_W-1:0];
                    state_next = tnd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tnd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tnd_pkg::ST_IDLE;
            phase_reg  <= tnd_pkg::PH_SKIP;
            neg_reg    <= 1'b0;
            value_reg  <= '0;
            count_reg  <= '0;
            bit_reg    <= '0;
            ovld_reg   <= 1'b0;
            clk_hz_reg <= tnd_pkg::CLOCK_HZ_RESET;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            value_reg <= value_next;
            count_reg <= count_next;
            bit_reg   <= bit_next;
            ovld_reg  <= ovld_next;
            if (cfg.valid && cfg.ready)
            begin
                clk_hz_reg <= cfg.input_clock_hz;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg   <= dig_next;
        hist_reg  <= hist_next;
        carry_reg <= carry_next;
        freq_reg  <= freq_next;
        ofreq_reg <= ofreq_next;
        odiv_reg  <= odiv_next;
    end

    assign char_in.ready       = (state_reg == tnd_pkg::ST_IDLE);
    assign cfg.ready           = 1'b1;
    assign tone_out.valid      = ovld_reg;
    assign tone_out.tone_freq  = ofreq_reg;
    assign tone_out.divider    = odiv_reg;
    assign tone_out.speaker_on = (ofreq_reg != '0);

endmodule
